// File: rtl/pts_pkg.sv
// ----------------------------------------------------------------------------
// pts_pkg
// Shared types and codes for the priority task scheduler: command and result
// beats, operation codes, task status codes, error codes and state codes.
// ----------------------------------------------------------------------------
package pts_pkg;

	typedef enum logic [2:0] {
		FN_TICK    = 3'd0,
		FN_ADD     = 3'd1,
		FN_SLEEP   = 3'd2,
		FN_SETPRIO = 3'd3,
		FN_ISR_IN  = 3'd4,
		FN_ISR_OUT = 3'd5,
		FN_SCHED   = 3'd6
	} func_t;

	typedef enum logic [1:0] {
		ST_DORMANT = 2'd0,
		ST_READY   = 2'd1,
		ST_ASLEEP  = 2'd2
	} status_t;

	localparam logic [1:0] ERR_NONE    = 2'd0;
	localparam logic [1:0] ERR_OFLOW   = 2'd1;
	localparam logic [1:0] ERR_UFLOW   = 2'd2;
	localparam logic [1:0] ERR_TIMEOUT = 2'd3;

	localparam logic [7:0] ISR_MAX = 8'd255;

	typedef struct packed {
		func_t       func;
		logic [3:0]  task_id;
		logic [2:0]  prio;
		logic [15:0] ticks;
	} cmd_t;

	typedef struct packed {
		logic [3:0] next_task;
		logic       next_valid;
		logic       switch_needed;
		logic [1:0] error;
		logic [7:0] ready_map;
	} res_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RD,
		S_EV,
		S_WR,
		S_TK_NX,
		S_UL,
		S_UL_PW,
		S_UL_NR,
		S_UL_NW,
		S_UL_END,
		S_AP,
		S_AP_W,
		S_ISR,
		S_PICK,
		S_DONE
	} state_t;

endpackage

// File: rtl/priority_task_scheduler.sv
// ----------------------------------------------------------------------------
// priority_task_scheduler
// Fixed-priority preemptive task scheduler with one FIFO ready queue per
// priority level, held as doubly linked lists in a task table memory.
// ----------------------------------------------------------------------------
// Each command beat produces exactly one result beat. The per-task record
// (priority, delay, status and both queue links) lives in a single RAM with
// one read and one write port, so tick, add, sleep and priority change are
// short sequences of read-modify-write steps on that RAM. A tick visits
// every task in turn; the steps of add, sleep and priority change depend on
// how many queue neighbours must be relinked. ISR entry, ISR exit and
// schedule do not touch the RAM. One command is worked on at a time, but the
// next command is taken while the previous result still waits in the output
// register. No clearing pass is needed after reset: a valid bit per table
// entry makes untouched entries read as dormant, with zero delay and empty
// links.
// ----------------------------------------------------------------------------
module priority_task_scheduler #(
	parameter int NUM_TASKS  = 16,
	parameter int NUM_PRIOS  = 8,
	parameter int DELAY_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  pts_pkg::cmd_t cmd,
	output logic          res_valid,
	input  logic          res_stall,
	output pts_pkg::res_t res
);
	import pts_pkg::*;

	localparam int TW = $clog2(NUM_TASKS);
	localparam int LW = TW + 1;
	localparam int PW = $clog2(NUM_PRIOS);
	localparam int DB = DELAY_BITS;
	localparam logic [LW-1:0] LNULL = '1;

	typedef struct packed {
		logic [PW-1:0] prio;
		logic [DB-1:0] delay;
		status_t       status;
		logic [LW-1:0] nxt;
		logic [LW-1:0] prv;
	} ent_t;

	localparam int EW = $bits(ent_t);

	// Control and sequencing registers.
	state_t        state_q, state_d;
	func_t         func_q;
	logic [TW-1:0] tidx_q;
	logic          tok_q;
	logic [PW-1:0] p_q;
	logic [DB-1:0] ticks_q;
	logic [TW-1:0] i_q;
	ent_t          ent_q;
	logic [PW-1:0] qp_q;
	logic [1:0]    err_q;
	logic          sw_q;

	// Queue heads and tails, ready map, ISR nesting and the current choice.
	logic [LW-1:0]        head_q [NUM_PRIOS];
	logic [LW-1:0]        tail_q [NUM_PRIOS];
	logic [NUM_PRIOS-1:0] ready_q;
	logic [7:0]           isr_q;
	logic [LW-1:0]        chosen_q;

	logic [NUM_TASKS-1:0] vld_q;
	logic                 rd_vld_q;

	res_t res_q;
	logic res_valid_q;

	// Task table port signals.
	logic          we, re;
	logic [TW-1:0] waddr, raddr;
	ent_t          wdata;
	logic [EW-1:0] ram_rdata;
	ent_t          rd_ent;

	// Combinational helpers.
	logic [TW-1:0] cur_idx;
	logic [LW-1:0] cur_lnk;
	logic [PW-1:0] qaddr;
	logic [LW-1:0] head_rd, tail_rd;
	logic [PW-1:0] best;
	logic          any_ready;
	logic          out_free;
	logic          accept;
	logic [PW-1:0] cmd_prio;
	logic [DB-1:0] cmd_ticks;
	logic [DB+15:0] ticks_pad;
	logic [DB-1:0] dec_delay;
	logic          tick_expire;
	logic [NUM_PRIOS+7:0] ready_pad;
	ent_t          ev_ent;
	logic [PW-1:0] ev_qp;

	pts_ram #(
		.WIDTH(EW),
		.DEPTH(NUM_TASKS)
	) u_task_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(ram_rdata)
	);

	// An entry never written reads as the reset record.
	always_comb begin
		if (rd_vld_q) begin
			rd_ent = ent_t'(ram_rdata);
		end else begin
			rd_ent = '{prio: '0, delay: '0, status: ST_DORMANT, nxt: LNULL, prv: LNULL};
		end
	end

	assign accept    = cmd_valid && !cmd_stall;
	assign cmd_stall = (state_q != S_IDLE);
	assign out_free  = !res_valid_q || !res_stall;

	// Saturate the command's priority and sleep length into the stored ranges.
	assign cmd_prio  = (int'(cmd.prio) >= NUM_PRIOS) ? PW'(NUM_PRIOS - 1) : PW'(cmd.prio);
	assign ticks_pad = {{DB{1'b0}}, cmd.ticks};
	assign cmd_ticks = (ticks_pad > {16'b0, {DB{1'b1}}}) ? {DB{1'b1}} : ticks_pad[DB-1:0];

	assign cur_idx = (func_q == FN_TICK) ? i_q : tidx_q;
	assign cur_lnk = {1'b0, cur_idx};

	assign dec_delay   = rd_ent.delay - 1'b1;
	assign tick_expire = (rd_ent.delay != '0) && (dec_delay == '0);

	// The record as modified by the current command, and the queue it acts on.
	always_comb begin
		ev_ent = rd_ent;
		ev_qp  = rd_ent.prio;
		case (func_q)
			FN_TICK: begin
				ev_ent.delay = dec_delay;
			end
			FN_ADD: begin
				ev_qp = p_q;
			end
			FN_SLEEP: begin
				ev_ent.status = ST_ASLEEP;
				ev_ent.delay  = ticks_q;
			end
			FN_SETPRIO: begin
				ev_ent.prio = p_q;
			end
			default: begin
			end
		endcase
	end

	// Highest non-empty priority queue.
	always_comb begin
		best      = '0;
		any_ready = 1'b0;
		for (int b = 0; b < NUM_PRIOS; b++) begin
			if (ready_q[b]) begin
				best      = PW'(b);
				any_ready = 1'b1;
			end
		end
	end

	// The head and tail tables are read at one queue per cycle.
	assign qaddr   = (state_q == S_PICK) ? best : qp_q;
	assign head_rd = head_q[qaddr];
	assign tail_rd = tail_q[qaddr];

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (cmd.func)
						FN_TICK, FN_ADD, FN_SLEEP, FN_SETPRIO: state_d = S_RD;
						FN_ISR_IN, FN_ISR_OUT:                 state_d = S_ISR;
						FN_SCHED:                              state_d = S_PICK;
						default:                               state_d = S_DONE;
					endcase
				end
			end
			S_RD: state_d = S_EV;
			S_EV: begin
				case (func_q)
					FN_TICK: begin
						if (tick_expire && rd_ent.status == ST_ASLEEP) begin
							state_d = S_AP;
						end else if (rd_ent.delay != '0) begin
							state_d = S_WR;
						end else begin
							state_d = S_TK_NX;
						end
					end
					FN_ADD: begin
						state_d = (tok_q && rd_ent.status == ST_DORMANT) ? S_AP : S_DONE;
					end
					FN_SLEEP: begin
						state_d = (tok_q && rd_ent.status == ST_READY) ? S_UL : S_DONE;
					end
					FN_SETPRIO: begin
						if (tok_q && rd_ent.prio != p_q) begin
							state_d = (rd_ent.status == ST_READY) ? S_UL : S_WR;
						end else begin
							state_d = S_DONE;
						end
					end
					default: state_d = S_DONE;
				endcase
			end
			S_WR:    state_d = (func_q == FN_TICK) ? S_TK_NX : S_DONE;
			S_TK_NX: state_d = (i_q == TW'(NUM_TASKS - 1)) ? S_DONE : S_RD;
			S_UL:    state_d = (ent_q.prv != LNULL) ? S_UL_PW : S_UL_NR;
			S_UL_PW: state_d = S_UL_NR;
			S_UL_NR: state_d = (ent_q.nxt != LNULL) ? S_UL_NW : S_UL_END;
			S_UL_NW: state_d = S_UL_END;
			S_UL_END: state_d = (func_q == FN_SLEEP) ? S_PICK : S_AP;
			S_AP: begin
				if (tail_rd != LNULL) begin
					state_d = S_AP_W;
				end else begin
					state_d = (func_q == FN_TICK) ? S_TK_NX : S_DONE;
				end
			end
			S_AP_W: state_d = (func_q == FN_TICK) ? S_TK_NX : S_DONE;
			S_ISR: begin
				state_d = (func_q == FN_ISR_OUT && isr_q != '0) ? S_PICK : S_DONE;
			end
			S_PICK: state_d = S_DONE;
			S_DONE: state_d = out_free ? S_IDLE : S_DONE;
			default: state_d = S_IDLE;
		endcase
	end

	// Task table port control.
	always_comb begin
		we    = 1'b0;
		waddr = cur_idx;
		wdata = ent_q;
		re    = 1'b0;
		raddr = cur_idx;
		case (state_q)
			S_RD: re = 1'b1;
			S_WR: we = 1'b1;
			S_UL: begin
				// The unlinked task keeps its new fields but loses both links.
				we        = 1'b1;
				wdata.nxt = LNULL;
				wdata.prv = LNULL;
				re        = (ent_q.prv != LNULL);
				raddr     = ent_q.prv[TW-1:0];
			end
			S_UL_PW: begin
				we        = 1'b1;
				waddr     = ent_q.prv[TW-1:0];
				wdata     = rd_ent;
				wdata.nxt = ent_q.nxt;
			end
			S_UL_NR: begin
				re    = (ent_q.nxt != LNULL);
				raddr = ent_q.nxt[TW-1:0];
			end
			S_UL_NW: begin
				we        = 1'b1;
				waddr     = ent_q.nxt[TW-1:0];
				wdata     = rd_ent;
				wdata.prv = ent_q.prv;
			end
			S_AP: begin
				we           = 1'b1;
				wdata.prio   = qp_q;
				wdata.status = ST_READY;
				wdata.nxt    = LNULL;
				wdata.prv    = tail_rd;
				re           = (tail_rd != LNULL);
				raddr        = tail_rd[TW-1:0];
			end
			S_AP_W: begin
				we        = 1'b1;
				waddr     = ent_q.prv[TW-1:0];
				wdata     = rd_ent;
				wdata.nxt = cur_lnk;
			end
			default: begin
			end
		endcase
	end

	assign ready_pad = {8'b0, ready_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			func_q      <= FN_TICK;
			tok_q       <= 1'b0;
			i_q         <= '0;
			err_q       <= ERR_NONE;
			sw_q        <= 1'b0;
			ready_q     <= '0;
			isr_q       <= '0;
			chosen_q    <= LNULL;
			vld_q       <= '0;
			rd_vld_q    <= 1'b0;
			res_valid_q <= 1'b0;
			for (int k = 0; k < NUM_PRIOS; k++) begin
				head_q[k] <= LNULL;
				tail_q[k] <= LNULL;
			end
		end else begin
			state_q <= state_d;
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			if (re) begin
				rd_vld_q <= vld_q[raddr];
			end
			// A result taken while the next one is being loaded is replaced below.
			if (res_valid_q && !res_stall && state_q != S_DONE) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						func_q  <= cmd.func;
						tidx_q  <= TW'(cmd.task_id);
						tok_q   <= (int'(cmd.task_id) < NUM_TASKS);
						p_q     <= cmd_prio;
						ticks_q <= cmd_ticks;
						i_q     <= '0;
						err_q   <= ERR_NONE;
						sw_q    <= 1'b0;
					end
				end
				S_EV: begin
					ent_q <= ev_ent;
					qp_q  <= ev_qp;
					if (func_q == FN_TICK && tick_expire && rd_ent.status != ST_ASLEEP) begin
						err_q <= ERR_TIMEOUT;
					end
				end
				S_TK_NX: begin
					i_q <= i_q + 1'b1;
				end
				S_UL: begin
					if (head_rd == cur_lnk) begin
						head_q[qp_q] <= ent_q.nxt;
					end
					if (tail_rd == cur_lnk) begin
						tail_q[qp_q] <= ent_q.prv;
					end
					if (head_rd == cur_lnk && ent_q.nxt == LNULL) begin
						ready_q[qp_q] <= 1'b0;
					end
				end
				S_UL_END: begin
					qp_q <= p_q;
				end
				S_AP: begin
					// The old tail is kept in the link field for the follow-up write.
					ent_q.prv    <= tail_rd;
					tail_q[qp_q] <= cur_lnk;
					if (tail_rd == LNULL) begin
						head_q[qp_q] <= cur_lnk;
					end
					ready_q[qp_q] <= 1'b1;
				end
				S_ISR: begin
					if (func_q == FN_ISR_IN) begin
						if (isr_q == ISR_MAX) begin
							err_q <= ERR_OFLOW;
						end else begin
							isr_q <= isr_q + 1'b1;
						end
					end else begin
						if (isr_q == '0) begin
							err_q <= ERR_UFLOW;
						end else begin
							isr_q <= isr_q - 1'b1;
						end
					end
				end
				S_PICK: begin
					if (isr_q == '0) begin
						if (!any_ready) begin
							chosen_q <= LNULL;
						end else if (head_rd != chosen_q) begin
							chosen_q <= head_rd;
							sw_q     <= 1'b1;
						end
					end
				end
				S_DONE: begin
					if (out_free) begin
						res_valid_q       <= 1'b1;
						res_q.next_valid    <= (chosen_q != LNULL);
						res_q.next_task     <= (chosen_q != LNULL) ? 4'(chosen_q) : 4'd0;
						res_q.switch_needed <= sw_q;
						res_q.error         <= err_q;
						res_q.ready_map     <= ready_pad[7:0];
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// File: rtl/pts_ram.sv
// ----------------------------------------------------------------------------
// pts_ram
// Generic single-write, single-read synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module pts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: rtl/pts_chk.sv
// ----------------------------------------------------------------------------
// pts_chk
// Port-level checks on the command and result channels of the scheduler.
// ----------------------------------------------------------------------------
module pts_chk (
	input logic          clk,
	input logic          arst_n,
	input logic          cmd_valid,
	input logic          cmd_stall,
	input logic          res_valid,
	input logic          res_stall,
	input pts_pkg::res_t res
);
	import pts_pkg::*;

	// A stalled result beat stays put.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("result beat changed while stalled");

	// A command beat is worked on alone, so the channel stalls right after it.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> cmd_stall)
		else $error("command channel open straight after a beat");

	// With no task chosen the task number reads as zero.
	a_idle_task: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.next_valid |-> res.next_task == 4'd0)
		else $error("task number set without a chosen task");

	// A context switch is only signalled towards a chosen task.
	a_switch: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.switch_needed |-> res.next_valid)
		else $error("switch flagged with no task chosen");

	// No operation that reports an error also changes the choice.
	a_err_switch: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.error != ERR_NONE |-> !res.switch_needed)
		else $error("switch flagged together with an error");

endmodule

bind priority_task_scheduler pts_chk u_pts_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.cmd_valid(cmd_valid),
	.cmd_stall(cmd_stall),
	.res_valid(res_valid),
	.res_stall(res_stall),
	.res      (res)
);
